// ===== hdl/tms_pkg.sv =====
// Shared constants, codes and controller/datapath types for the tone melody sequencer.
package tms_pkg;

  localparam int NOTE_DEPTH = 256;
  localparam int ADDR_W     = $clog2(NOTE_DEPTH);
  localparam int INDEX_W    = 8;
  localparam int POS_W      = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;

  localparam int OP_W      = 2;
  localparam int FREQ_W    = 15;
  localparam int DUR_W     = 15;
  localparam int NOTE_W    = FREQ_W + DUR_W;
  localparam int TICK_W    = 16;
  localparam int CLK_W     = 24;
  localparam int PERIOD_W  = 16;
  localparam int COMPARE_W = 15;
  localparam int REM_W     = 27;
  localparam int MS_W      = 10;
  localparam int DUR_US_W  = DUR_W + MS_W;
  localparam int CNT_W     = $clog2(CLK_W + 1);

  localparam logic [MS_W-1:0]   MS_TO_US          = 10'd1000;
  localparam logic [TICK_W-1:0] TICK_US_RESET     = 16'd682;
  localparam logic [CLK_W-1:0]  TIMER_CLOCK_RESET = 24'd1500000;

  localparam int PADDR_W    = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_TICK_US     = 1'b0,
    REG_TIMER_CLOCK = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic eval;
    logic div_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== hdl/tms_if.sv =====
// Request and result channel interfaces for the tone melody sequencer.
interface tms_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tms_pkg::OP_W-1:0]     op;
  logic [tms_pkg::INDEX_W-1:0]  index;
  logic [tms_pkg::FREQ_W-1:0]   frequency;
  logic [tms_pkg::DUR_W-1:0]    duration_ms;

  modport source (output valid, op, index, frequency, duration_ms, input ready);
  modport sink (input valid, op, index, frequency, duration_ms, output ready);
endinterface

interface tms_res_if;
  logic                           valid;
  logic                           ready;
  logic                           playing;
  logic                           tone_on;
  logic [tms_pkg::PERIOD_W-1:0]   period;
  logic [tms_pkg::COMPARE_W-1:0]  compare;
  logic [tms_pkg::INDEX_W-1:0]    position;

  modport source (output valid, playing, tone_on, period, compare, position, input ready);
  modport sink (input valid, playing, tone_on, period, compare, position, output ready);
endinterface

// ===== hdl/tms_regs.sv =====
// APB configuration registers: tick length and tone timer clock.
module tms_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tms_pkg::PADDR_W-1:0]       paddr,
  input  logic [tms_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tms_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [tms_pkg::TICK_W-1:0]        tick_us,
  output logic [tms_pkg::CLK_W-1:0]         timer_clock
);

  tms_pkg::reg_idx_t reg_sel;
  logic              wr_en;

  assign reg_sel = tms_pkg::reg_idx_t'(paddr[tms_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_us     <= tms_pkg::TICK_US_RESET;
      timer_clock <= tms_pkg::TIMER_CLOCK_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        tms_pkg::REG_TICK_US:     tick_us     <= pwdata[tms_pkg::TICK_W-1:0];
        tms_pkg::REG_TIMER_CLOCK: timer_clock <= pwdata[tms_pkg::CLK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tms_pkg::REG_TICK_US:     prdata = tms_pkg::APB_DATA_W'(tick_us);
      tms_pkg::REG_TIMER_CLOCK: prdata = tms_pkg::APB_DATA_W'(timer_clock);
    endcase
  end

endmodule

// ===== hdl/tms_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tone period.
module tms_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tms_pkg::CLK_W-1:0]   dividend,
  input  logic [tms_pkg::FREQ_W-1:0]  divisor,
  output logic                        done,
  output logic [tms_pkg::CLK_W-1:0]   quotient
);

  logic                        busy;
  logic [tms_pkg::CNT_W-1:0]   cnt;
  logic [tms_pkg::FREQ_W-1:0]  rem;
  logic [tms_pkg::FREQ_W-1:0]  dvs;
  logic [tms_pkg::FREQ_W:0]    trial;
  logic [tms_pkg::FREQ_W:0]    diff;
  logic                        fits;

  assign trial = {rem, quotient[tms_pkg::CLK_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == tms_pkg::CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= tms_pkg::CNT_W'(tms_pkg::CLK_W);
      end else if (busy) begin
        cnt <= cnt - tms_pkg::CNT_W'(1);
        if (cnt == tms_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[tms_pkg::CLK_W-2:0], fits};
      rem      <= fits ? diff[tms_pkg::FREQ_W-1:0] : trial[tms_pkg::FREQ_W-1:0];
    end
  end

endmodule

// ===== hdl/tms_ctrl.sv =====
// Sequencing state machine: fetch, evaluate, divide and hand over the result.
module tms_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tms_pkg::ctrl_status_t  status,
  output tms_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_FETCH;
            in_ready <= 1'b0;
          end
        end
        ST_FETCH: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= status.need_div ? ST_DIVIDE : ST_FINISH;
        end
        ST_DIVIDE: begin
          if (status.div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.capture   = (state == ST_IDLE) && in_valid && in_ready;
    cmd.fetch     = (state == ST_FETCH);
    cmd.eval      = (state == ST_EVAL);
    cmd.div_start = (state == ST_EVAL) && status.need_div;
    cmd.finish    = (state == ST_FINISH) && status.out_free;
  end

endmodule

// ===== hdl/tms_datapath.sv =====
// Note store, playback state, tone period and result register.
module tms_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tms_pkg::ctrl_cmd_t            cmd,
  output tms_pkg::ctrl_status_t         status,
  input  logic [tms_pkg::OP_W-1:0]      op,
  input  logic [tms_pkg::INDEX_W-1:0]   index,
  input  logic [tms_pkg::FREQ_W-1:0]    frequency,
  input  logic [tms_pkg::DUR_W-1:0]     duration_ms,
  input  logic [tms_pkg::TICK_W-1:0]    tick_us,
  input  logic [tms_pkg::CLK_W-1:0]     timer_clock,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          playing,
  output logic                          tone_on,
  output logic [tms_pkg::PERIOD_W-1:0]  period,
  output logic [tms_pkg::COMPARE_W-1:0] compare,
  output logic [tms_pkg::INDEX_W-1:0]   position
);

  logic [tms_pkg::NOTE_W-1:0] note_mem [tms_pkg::NOTE_DEPTH];

  tms_pkg::op_t                   op_q;
  logic [tms_pkg::POS_W-1:0]      idx_q;
  logic [tms_pkg::FREQ_W-1:0]     freq_q;
  logic [tms_pkg::DUR_W-1:0]      dur_q;

  logic                           song_active;
  logic                           tone_running;
  logic [tms_pkg::POS_W-1:0]      next_position;
  logic signed [tms_pkg::REM_W-1:0] remaining_us;
  logic [tms_pkg::PERIOD_W-1:0]   tone_period;

  logic [tms_pkg::POS_W-1:0]      fetch_sel;
  logic [tms_pkg::POS_W-1:0]      fetch_pos;
  logic [tms_pkg::NOTE_W-1:0]     rd_data;
  logic                           wr_en;

  logic [tms_pkg::FREQ_W-1:0]     rd_freq;
  logic [tms_pkg::DUR_W-1:0]      rd_dur;
  logic [tms_pkg::DUR_US_W-1:0]   dur_us;
  logic                           in_range;
  logic                           is_end;
  logic                           rem_le0;
  logic                           note_due;
  logic                           load_now;
  logic                           halt_now;

  logic                           div_done;
  logic [tms_pkg::CLK_W-1:0]      quotient;

  assign fetch_sel = (op_q == tms_pkg::OP_TICK) ? next_position : idx_q;
  assign wr_en     = cmd.fetch && (op_q == tms_pkg::OP_LOAD)
                     && (idx_q < tms_pkg::POS_W'(tms_pkg::NOTE_DEPTH));

  assign rd_freq  = rd_data[tms_pkg::NOTE_W-1:tms_pkg::DUR_W];
  assign rd_dur   = rd_data[tms_pkg::DUR_W-1:0];
  assign dur_us   = rd_dur * tms_pkg::MS_TO_US;
  assign in_range = fetch_pos < tms_pkg::POS_W'(tms_pkg::NOTE_DEPTH);
  assign is_end   = !in_range || (rd_data == '0);
  assign rem_le0  = remaining_us[tms_pkg::REM_W-1] || (remaining_us == '0);
  assign note_due = (op_q == tms_pkg::OP_TICK) && song_active && rem_le0;
  assign load_now = ((op_q == tms_pkg::OP_START) || note_due) && !is_end;
  assign halt_now = ((op_q == tms_pkg::OP_START) && is_end) || (note_due && is_end)
                    || (op_q == tms_pkg::OP_STOP);

  assign status.need_div = load_now && (rd_freq != '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  tms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (timer_clock),
    .divisor  (rd_freq),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      if (wr_en) begin
        note_mem[fetch_sel[tms_pkg::ADDR_W-1:0]] <= {freq_q, dur_q};
      end
      rd_data <= note_mem[fetch_sel[tms_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= tms_pkg::op_t'(op);
      idx_q  <= tms_pkg::POS_W'(index);
      freq_q <= frequency;
      dur_q  <= duration_ms;
    end
    if (cmd.fetch) begin
      fetch_pos <= fetch_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      song_active   <= 1'b0;
      tone_running  <= 1'b0;
      next_position <= '0;
      remaining_us  <= '0;
      tone_period   <= '0;
    end else begin
      if (cmd.fetch && (op_q == tms_pkg::OP_TICK) && song_active) begin
        remaining_us <= remaining_us
                        - $signed({{(tms_pkg::REM_W - tms_pkg::TICK_W){1'b0}}, tick_us});
      end
      if (cmd.eval) begin
        if (halt_now) begin
          song_active  <= 1'b0;
          tone_running <= 1'b0;
          if (op_q == tms_pkg::OP_START) begin
            next_position <= fetch_pos;
          end
        end
        if (load_now) begin
          song_active   <= 1'b1;
          remaining_us  <= tms_pkg::REM_W'(dur_us);
          next_position <= fetch_pos + tms_pkg::POS_W'(1);
          if (rd_freq == '0) begin
            tone_running <= 1'b0;
          end
        end
      end
      if (div_done) begin
        tone_running <= 1'b1;
        tone_period  <= (|quotient[tms_pkg::CLK_W-1:tms_pkg::PERIOD_W])
                        ? '1 : quotient[tms_pkg::PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      playing  <= song_active;
      tone_on  <= tone_running;
      period   <= tone_period;
      compare  <= tone_period[tms_pkg::PERIOD_W-1:1];
      position <= next_position[tms_pkg::INDEX_W-1:0];
    end
  end

endmodule

// ===== hdl/tone_melody_sequencer.sv =====
// Top level of the tone melody sequencer: registers, controller and datapath.
//
//   channel  direction  handshake        payload
//   cmd      in         valid/ready      op, index, frequency, duration_ms
//   res      out        valid/ready      playing, tone_on, period, compare, position
//   apb      in         psel/penable     tick_us at 0x0, timer_clock at 0x4
//
// The result is registered in the finish state, after fetch and evaluate, and after
// the divide state when a request loads a sounding note: the tone period comes from
// a 24-step restoring divider. The next request is accepted back in the idle state.
// A new request is taken once the previous one has finished, even while its
// result still waits in the output register.
// Synchronous reset clears playback state; the note store is not cleared.
module tone_melody_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  tms_cmd_if.sink                         cmd,
  tms_res_if.source                       res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tms_pkg::PADDR_W-1:0]     paddr,
  input  logic [tms_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tms_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  tms_pkg::ctrl_cmd_t            ctrl_cmd;
  tms_pkg::ctrl_status_t         ctrl_status;
  logic [tms_pkg::TICK_W-1:0]    tick_us;
  logic [tms_pkg::CLK_W-1:0]     timer_clock;

  tms_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_us     (tick_us),
    .timer_clock (timer_clock)
  );

  tms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .status   (ctrl_status),
    .cmd      (ctrl_cmd)
  );

  tms_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctrl_cmd),
    .status      (ctrl_status),
    .op          (cmd.op),
    .index       (cmd.index),
    .frequency   (cmd.frequency),
    .duration_ms (cmd.duration_ms),
    .tick_us     (tick_us),
    .timer_clock (timer_clock),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .playing     (res.playing),
    .tone_on     (res.tone_on),
    .period      (res.period),
    .compare     (res.compare),
    .position    (res.position)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the tone melody sequencer: directed table, then random songs.
module tb;
  import tms_pkg::*;

  typedef struct packed {
    logic                 playing;
    logic                 tone_on;
    logic [PERIOD_W-1:0]  period;
    logic [COMPARE_W-1:0] compare;
    logic [INDEX_W-1:0]   position;
  } tone_result_t;

  typedef struct {
    bit                   cfg;
    reg_idx_t             sel;
    logic [31:0]          value;
    op_t                  op;
    logic [INDEX_W-1:0]   idx;
    logic [FREQ_W-1:0]    freq;
    logic [DUR_W-1:0]     dur;
    bit                   typed;
    tone_result_t         want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  tms_cmd_if cmd ();
  tms_res_if res ();

  tone_melody_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [FREQ_W-1:0]  note_freq [NOTE_DEPTH];
  logic [DUR_W-1:0]   note_dur  [NOTE_DEPTH];
  logic [TICK_W-1:0]  cfg_tick = TICK_US_RESET;
  logic [CLK_W-1:0]   cfg_clk  = TIMER_CLOCK_RESET;
  bit                 song_on = 0;
  bit                 tone_live = 0;
  int unsigned        next_pos = 0;
  int                 remain_us = 0;
  logic [PERIOD_W-1:0] tone_per = '0;

  tone_result_t expected_tones[$];
  plan_row_t    plan[$];
  int  mismatches = 0;
  int  tones_seen = 0;
  int  requests_sent = 0;
  int  reg_writes = 0;
  int  notes_started = 0;
  int  songs_ended = 0;
  bit  calm = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  function automatic bit song_over(int unsigned pos);
    if (pos >= NOTE_DEPTH) return 1;
    return note_freq[pos] == 0 && note_dur[pos] == 0;
  endfunction

  function automatic void take_note(int unsigned pos);
    int unsigned q;
    if (note_freq[pos] == 0) begin
      tone_live = 0;
    end else begin
      q = 32'(cfg_clk) / 32'(note_freq[pos]);
      tone_per = (q > 65535) ? 16'hFFFF : q[15:0];
      tone_live = 1;
    end
    remain_us = int'(note_dur[pos]) * 1000;
    next_pos = pos + 1;
    notes_started++;
  endfunction

  function automatic tone_result_t advance_melody(op_t op, logic [INDEX_W-1:0] idx,
                                                   logic [FREQ_W-1:0] freq,
                                                   logic [DUR_W-1:0] dur);
    tone_result_t r;
    case (op)
      OP_LOAD: begin
        note_freq[idx] = freq;
        note_dur[idx] = dur;
      end
      OP_START: begin
        if (song_over(idx)) begin
          next_pos = idx;
          song_on = 0;
          tone_live = 0;
          songs_ended++;
        end else begin
          song_on = 1;
          take_note(idx);
        end
      end
      OP_TICK: begin
        if (song_on) begin
          remain_us = remain_us - int'(cfg_tick);
          if (remain_us <= 0) begin
            if (song_over(next_pos)) begin
              song_on = 0;
              tone_live = 0;
              songs_ended++;
            end else begin
              take_note(next_pos);
            end
          end
        end
      end
      default: begin
        song_on = 0;
        tone_live = 0;
      end
    endcase
    r.playing = song_on;
    r.tone_on = tone_live;
    r.period = tone_per;
    r.compare = tone_per[15:1];
    r.position = next_pos[7:0];
    return r;
  endfunction

  function automatic tone_result_t tone(bit p, bit t, int per, int cmp, int pos);
    tone_result_t r;
    r.playing = p;
    r.tone_on = t;
    r.period = per[15:0];
    r.compare = cmp[14:0];
    r.position = pos[7:0];
    return r;
  endfunction

  function automatic plan_row_t req_row(op_t op, int idx, int freq, int dur);
    plan_row_t r;
    r.cfg = 0;
    r.sel = REG_TICK_US;
    r.value = '0;
    r.op = op;
    r.idx = idx[7:0];
    r.freq = freq[14:0];
    r.dur = dur[14:0];
    r.typed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t sure_row(op_t op, int idx, int freq, int dur,
                                         tone_result_t want);
    plan_row_t r;
    r = req_row(op, idx, freq, dur);
    r.typed = 1;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_t sel, int unsigned value);
    plan_row_t r;
    r = req_row(OP_TICK, 0, 0, 0);
    r.cfg = 1;
    r.sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned max_ms;
    if ($urandom_range(0, 99) < 3) return DUR_W'($urandom);
    max_ms = (int'(cfg_tick) * 6) / 1000;
    return DUR_W'($urandom_range(0, max_ms));
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_tone();
    tone_result_t w;
    tones_seen++;
    if (expected_tones.size() == 0) begin
      $display("%0t: result with none expected, got playing %0d tone %0d period %0d",
               $time, res.playing, res.tone_on, res.period);
      mismatches++;
    end else begin
      w = expected_tones.pop_front();
      check_field("playing", w.playing, res.playing);
      check_field("tone_on", w.tone_on, res.tone_on);
      check_field("period", w.period, res.period);
      check_field("compare", w.compare, res.compare);
      check_field("position", w.position, res.position);
    end
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    res.ready = 0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) check_tone();
      if (!held && tones_seen >= 450) begin
        held = 1;
        stall = 300;
      end else if (stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 11);
      end
      if (stall > 0) begin
        stall--;
        res.ready <= 0;
      end else begin
        res.ready <= 1;
      end
    end
  end

  task automatic send_req(op_t op, logic [INDEX_W-1:0] idx, logic [FREQ_W-1:0] freq,
                          logic [DUR_W-1:0] dur, bit typed, tone_result_t want);
    tone_result_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.op <= op;
    cmd.index <= idx;
    cmd.frequency <= freq;
    cmd.duration_ms <= dur;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pred = advance_melody(op, idx, freq, dur);
    expected_tones.push_back(typed ? want : pred);
    requests_sent++;
  endtask

  task automatic drain();
    cmd.valid <= 0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t sel, logic [31:0] value);
    logic [31:0] kept;
    kept = (sel == REG_TICK_US) ? (value & 32'hFFFF) : (value & 32'hFF_FFFF);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_TICK_US) cfg_tick = kept[TICK_W-1:0];
    else cfg_clk = kept[CLK_W-1:0];
    reg_writes++;
    // read back
    pwrite <= 0;
    penable <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("register readback", kept, prdata);
    psel <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  task automatic random_note(logic [INDEX_W-1:0] idx);
    int k;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0] d;
    k = $urandom_range(0, 99);
    d = pick_duration();
    if (k < 8) begin
      f = '0;
      d = '0;
    end else if (k < 20) begin
      f = '0;
    end else if (k < 55) begin
      f = FREQ_W'($urandom_range(1, 200));
    end else begin
      f = FREQ_W'($urandom_range(1, 32767));
    end
    send_req(OP_LOAD, idx, f, d, 0, '0);
  endtask

  task automatic random_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 58) send_req(OP_TICK, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom),
                         0, '0);
    else if (k < 70) send_req(OP_START, INDEX_W'($urandom_range(0, 255)), FREQ_W'($urandom),
                              DUR_W'($urandom), 0, '0);
    else if (k < 95) random_note(INDEX_W'($urandom));
    else send_req(OP_STOP, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom), 0, '0);
  endtask

  initial begin
    int unsigned phase_tick [5];
    int unsigned phase_clk [5];
    rst = 1;
    cmd.valid = 0;
    cmd.op = OP_LOAD;
    cmd.index = '0;
    cmd.frequency = '0;
    cmd.duration_ms = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    plan.push_back(sure_row(OP_TICK, 0, 0, 0, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_STOP, 0, 0, 0, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_LOAD, 0, 1, 0, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_LOAD, 1, 32767, 32767, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_LOAD, 2, 0, 1, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_LOAD, 3, 0, 0, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_LOAD, 255, 440, 1, tone(0, 0, 0, 0, 0)));
    plan.push_back(sure_row(OP_START, 0, 0, 0, tone(1, 1, 65535, 32767, 1)));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_LOAD, 4, 1000, 0));
    plan.push_back(req_row(OP_START, 2, 0, 0));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_START, 3, 0, 0));
    plan.push_back(req_row(OP_START, 255, 0, 0));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_START, 255, 0, 0));
    plan.push_back(req_row(OP_STOP, 0, 0, 0));
    plan.push_back(cfg_row(REG_TICK_US, 0));
    plan.push_back(cfg_row(REG_TIMER_CLOCK, 0));
    plan.push_back(sure_row(OP_START, 0, 0, 0, tone(1, 1, 0, 0, 1)));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_STOP, 0, 0, 0));
    plan.push_back(cfg_row(REG_TICK_US, 65535));
    plan.push_back(cfg_row(REG_TIMER_CLOCK, 16777215));
    plan.push_back(sure_row(OP_START, 1, 0, 0, tone(1, 1, 512, 256, 2)));
    plan.push_back(req_row(OP_TICK, 0, 0, 0));
    plan.push_back(req_row(OP_STOP, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        drain();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_req(plan[i].op, plan[i].idx, plan[i].freq, plan[i].dur, plan[i].typed,
                 plan[i].want);
      end
    end

    phase_tick = '{682, 65535, 1000, 1, 0};
    phase_clk = '{1500000, 16777215, 8000000, 1, 0};
    phase_tick[4] = $urandom_range(300, 3000);
    phase_clk[4] = $urandom_range(1, 16777215);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(REG_TICK_US, phase_tick[p]);
      write_reg(REG_TIMER_CLOCK, phase_clk[p]);
      if (p == 0) begin
        for (int i = 0; i < NOTE_DEPTH; i++) random_note(INDEX_W'(i));
      end
      if (p == 4) calm = 1;
      repeat (110) random_req();
    end

    cmd.valid <= 0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Run covered %0d requests, %0d register writes, %0d results checked",
             requests_sent, reg_writes, tones_seen);
    $display("Notes started: %0d, songs ended by terminator or store end: %0d",
             notes_started, songs_ended);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
